// ===== rtl/crse_pkg.sv =====
// Shared types, constants and register codes of the column run segment encoder.
package crse_pkg;

    localparam int DEFAULT_MAX_DIM = 4096;
    localparam int CFG_W           = 13;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 13;
    localparam int PIX_W           = 8;
    localparam int SX_W            = 14;
    localparam int SY_W            = 13;
    localparam int FIFO_DEPTH      = 4;
    localparam int LUMA_SUM_W      = 25;

    localparam logic [15:0]      LUMA_R_COEF  = 16'd19595;
    localparam logic [15:0]      LUMA_G_COEF  = 16'd38469;
    localparam logic [15:0]      LUMA_B_COEF  = 16'd7472;
    localparam logic [PIX_W-1:0] RED_THRESH   = 8'd30;
    localparam logic [7:0]       QUANT_RECIP  = 8'd241;
    localparam int               QUANT_SHIFT  = 12;
    localparam logic [PIX_W-1:0] GRAY_FULL    = 8'd15;
    localparam logic [PIX_W-1:0] GRAY_FLUSH   = 8'd255;
    localparam logic [CFG_W-1:0] DIM_RESET    = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_MODE    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             scan_mode;
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             red_lit;
        logic             last_sample;
    } t_luma_item;

    typedef struct packed {
        logic signed [SX_W-1:0] start_x;
        logic signed [SY_W-1:0] start_y;
        logic signed [SX_W-1:0] end_x;
        logic signed [SY_W-1:0] end_y;
        logic [PIX_W-1:0]       gray_level;
        logic                   last;
    } t_seg;

endpackage

// ===== rtl/crse_if.sv =====
// Valid/ready channel interfaces for pixel samples and segments.
interface crse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_sample;

    modport source (output valid, output red, output green, output blue,
                    output last_sample, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_sample, output ready);
endinterface

interface crse_out_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] start_x;
    logic signed [12:0] start_y;
    logic signed [13:0] end_x;
    logic signed [12:0] end_y;
    logic [7:0]         gray_level;
    logic               last;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, output gray_level, output last, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, input gray_level, input last, output ready);
endinterface

// ===== rtl/crse_luma.sv =====
// Input register and luma product stage of the sample pipeline.
module crse_luma (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    crse_in_if.sink               i_pix,
    output logic                  o_item_v,
    output crse_pkg::t_luma_item  o_item,
    input  logic                  i_item_take
);
    import crse_pkg::*;

    logic             r_s1_v;
    logic [PIX_W-1:0] r_red;
    logic [PIX_W-1:0] r_green;
    logic [PIX_W-1:0] r_blue;
    logic             r_last;
    logic             r_s2_v;
    t_luma_item       r_item;

    logic                  s2_free;
    logic                  s1_go;
    logic                  s1_free;
    logic [LUMA_SUM_W-1:0] luma_sum;
    t_luma_item            n_item;

    assign s2_free     = !r_s2_v || i_item_take;
    assign s1_go       = r_s1_v && s2_free;
    assign s1_free     = !r_s1_v || s1_go;
    assign i_pix.ready = s1_free;

    always_comb begin
        luma_sum = LUMA_SUM_W'(r_red)   * LUMA_SUM_W'(LUMA_R_COEF)
                 + LUMA_SUM_W'(r_green) * LUMA_SUM_W'(LUMA_G_COEF)
                 + LUMA_SUM_W'(r_blue)  * LUMA_SUM_W'(LUMA_B_COEF);
        n_item.luma        = luma_sum[16 +: PIX_W];
        n_item.red_lit     = r_red > RED_THRESH;
        n_item.last_sample = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= i_pix.valid;
            end
            if (s2_free) begin
                r_s2_v <= s1_go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && s1_free) begin
            r_red   <= i_pix.red;
            r_green <= i_pix.green;
            r_blue  <= i_pix.blue;
            r_last  <= i_pix.last_sample;
        end
        if (s1_go) begin
            r_item <= n_item;
        end
    end

    assign o_item_v = r_s2_v;
    assign o_item   = r_item;
endmodule

// ===== rtl/crse_run.sv =====
// Pixel classification, position counters and vertical run tracking.
module crse_run #(
    parameter int MAX_DIM = crse_pkg::DEFAULT_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  crse_pkg::t_cfg       i_cfg,
    input  logic                 i_take,
    input  crse_pkg::t_luma_item i_item,
    output logic [1:0]           o_push_n,
    output crse_pkg::t_seg       o_seg0,
    output crse_pkg::t_seg       o_seg1
);
    import crse_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int XW    = CNT_W + 1;
    localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic             r_open, n_open;
    logic [XW-1:0]    r_sx, n_sx;
    logic [CNT_W-1:0] r_sy, n_sy;
    logic [CNT_W-1:0] r_ey, n_ey;
    logic [PIX_W-1:0] r_rgray, n_rgray;
    logic             r_found, n_found;
    logic [PIX_W-1:0] r_pgray, n_pgray;

    logic [CMP_W-1:0] w_cl;
    logic [CMP_W-1:0] h_cl;
    logic [15:0]      quant_prod;
    logic [3:0]       quant;
    logic             lit_s;
    logic [PIX_W-1:0] gray_s;
    logic             eff_found;
    logic [PIX_W-1:0] eff_gray;
    logic [XW-1:0]    x;
    logic             extend;
    logic             emit0;
    logic             row_last;
    logic             col_last;
    logic             frame_end;
    t_seg             seg_reg;
    t_seg             seg_flush;

    always_comb begin
        w_cl = (i_cfg.image_width == '0) ? CMP_W'(1)
             : (CMP_W'(i_cfg.image_width) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
             : CMP_W'(i_cfg.image_width);
        h_cl = (i_cfg.image_height == '0) ? CMP_W'(1)
             : (CMP_W'(i_cfg.image_height) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
             : CMP_W'(i_cfg.image_height);

        quant_prod = 16'(i_item.luma) * 16'(QUANT_RECIP);
        quant      = quant_prod[QUANT_SHIFT +: 4];
        lit_s      = i_cfg.scan_mode ? (quant != 4'd0) : i_item.red_lit;
        gray_s     = i_cfg.scan_mode ? PIX_W'(quant) : i_item.luma;
        eff_found  = r_found || lit_s;
        eff_gray   = r_found ? r_pgray : gray_s;

        x      = i_cfg.scan_mode ? (XW'(r_col) + XW'(1)) : XW'(r_col);
        extend = (XW'(r_row) == XW'(r_ey) + XW'(1)) && (r_sx == x)
              && (eff_gray == r_rgray);

        row_last  = (CMP_W'(r_row) + CMP_W'(1)) >= h_cl;
        col_last  = (CMP_W'(r_col) + CMP_W'(1)) >= w_cl;
        frame_end = i_item.last_sample && row_last && col_last;
        emit0     = i_item.last_sample && eff_found && r_open && !extend;

        seg_reg.start_x    = SX_W'(r_sx);
        seg_reg.start_y    = SY_W'(r_sy);
        seg_reg.end_x      = SX_W'(r_sx);
        seg_reg.end_y      = SY_W'(r_ey);
        seg_reg.gray_level = (i_cfg.scan_mode && (XW'(r_ey) > XW'(r_sy) + XW'(1)))
                           ? GRAY_FULL : r_rgray;
        seg_reg.last       = 1'b0;

        n_col   = r_col;
        n_row   = r_row;
        n_open  = r_open;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_ey    = r_ey;
        n_rgray = r_rgray;
        n_found = r_found;
        n_pgray = r_pgray;

        if (i_item.last_sample) begin
            n_found = 1'b0;
            n_pgray = '0;
            if (eff_found) begin
                if (r_open && extend) begin
                    n_ey = r_row;
                end else begin
                    n_open  = 1'b1;
                    n_sx    = x;
                    n_sy    = r_row;
                    n_ey    = r_row;
                    n_rgray = eff_gray;
                end
            end
            if (row_last) begin
                n_row = '0;
                n_col = col_last ? '0 : r_col + CNT_W'(1);
            end else begin
                n_row = r_row + CNT_W'(1);
            end
        end else begin
            n_found = eff_found;
            n_pgray = eff_gray;
        end

        seg_flush.start_x    = n_open ? SX_W'(n_sx) : '1;
        seg_flush.start_y    = n_open ? SY_W'(n_sy) : '1;
        seg_flush.end_x      = n_open ? SX_W'(n_sx) : '1;
        seg_flush.end_y      = n_open ? SY_W'(n_ey) : '1;
        seg_flush.gray_level = GRAY_FLUSH;
        seg_flush.last       = 1'b1;

        if (frame_end) begin
            n_open  = 1'b0;
            n_rgray = '0;
        end

        o_seg0   = emit0 ? seg_reg : seg_flush;
        o_seg1   = seg_flush;
        o_push_n = i_take ? (2'(emit0) + 2'(frame_end)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_open  <= 1'b0;
            r_found <= 1'b0;
            r_pgray <= '0;
            r_rgray <= '0;
        end else if (i_take) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_open  <= n_open;
            r_found <= n_found;
            r_pgray <= n_pgray;
            r_rgray <= n_rgray;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_ey <= n_ey;
        end
    end
endmodule

// ===== rtl/crse_seg_fifo.sv =====
// Result queue taking up to two segments a cycle and releasing one while the output is ready.
module crse_seg_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_push_n,
    input  crse_pkg::t_seg i_seg0,
    input  crse_pkg::t_seg i_seg1,
    output logic           o_room,
    crse_out_if.source     o_seg
);
    import crse_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_seg             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;
    logic [PTR_W-1:0] wp1;
    t_seg             head;

    assign pop    = o_seg.valid && o_seg.ready;
    assign wp1    = r_wp + PTR_W'(1);
    assign o_room = r_count <= CNT_W'(FIFO_DEPTH - 2);

    always_comb begin
        n_wp    = r_wp + PTR_W'(i_push_n);
        n_rp    = pop ? r_rp + PTR_W'(1) : r_rp;
        n_count = r_count + CNT_W'(i_push_n) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_seg0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wp1] <= i_seg1;
        end
    end

    assign head             = r_mem[r_rp];
    assign o_seg.valid      = r_count != '0;
    assign o_seg.start_x    = head.start_x;
    assign o_seg.start_y    = head.start_y;
    assign o_seg.end_x      = head.end_x;
    assign o_seg.end_y      = head.end_y;
    assign o_seg.gray_level = head.gray_level;
    assign o_seg.last       = head.last;
endmodule

// ===== rtl/column_run_segment_encoder_core.sv =====
// Top level of the column run segment encoder: configuration registers and datapath.
//
// Accepts one RGB sample per clock with no gaps of its own. A sample passes an input
// register, a luma product register and the run tracker, which writes zero, one or
// two segments into a four-entry result queue read out one per clock while the output
// is ready; each segment is presented on the output from the head of that queue.
// Input stalls only when the result queue has fewer than two free entries, which
// happens only under output back-pressure.
// Write configuration only while no transaction is in flight.
module column_run_segment_encoder_core #(
    parameter int MAX_DIM = crse_pkg::DEFAULT_MAX_DIM
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    crse_in_if.sink                           i_pix,
    crse_out_if.source                        o_seg,
    input  logic                              i_cfg_we,
    input  logic [crse_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [crse_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import crse_pkg::*;

    t_cfg       r_cfg;
    logic       item_v;
    t_luma_item item;
    logic       room;
    logic       take;
    logic [1:0] push_n;
    t_seg       seg0;
    t_seg       seg1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_mode    <= 1'b0;
            r_cfg.image_width  <= DIM_RESET;
            r_cfg.image_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SCAN_MODE:    r_cfg.scan_mode    <= i_cfg_data[0];
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= CFG_W'(i_cfg_data);
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= CFG_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign take = item_v && room;

    crse_luma u_luma (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .o_item_v    (item_v),
        .o_item      (item),
        .i_item_take (take)
    );

    crse_run #(
        .MAX_DIM (MAX_DIM)
    ) u_run (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_take   (take),
        .i_item   (item),
        .o_push_n (push_n),
        .o_seg0   (seg0),
        .o_seg1   (seg1)
    );

    crse_seg_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_seg0   (seg0),
        .i_seg1   (seg1),
        .o_room   (room),
        .o_seg    (o_seg)
    );
endmodule
